// File: src/ogs_pkg.sv
// Shared types, fixed-point formats and latencies for the 3x3 row orthonormalizer.
// Used by the top level, ogs_norm and ogs_proj; it depends on nothing else.
package ogs_pkg;

    localparam int unsigned DATA_BITS     = 16;
    localparam int unsigned GUARD_BITS    = 14;
    localparam int unsigned UNIT_BITS     = 30;
    localparam int unsigned OUT_FRAC_BITS = 14;
    localparam int unsigned OUT_SHIFT     =
        (OUT_FRAC_BITS >= UNIT_BITS) ? 0 : UNIT_BITS - OUT_FRAC_BITS;

    localparam int unsigned W_BITS    = 32;
    localparam int unsigned S_BITS    = 34;
    localparam int unsigned ROOT_BITS = 32;
    localparam int unsigned QUO_BITS  = 31;
    localparam int unsigned X_BITS    = 33;
    localparam int unsigned NUM_BITS  = 63;
    localparam int unsigned RND_BITS  = 80;

    // Four front stages, one stage per root bit, one setup stage, one stage
    // per quotient bit and the final clamp.
    localparam int unsigned NORM_LAT = 4 + ROOT_BITS + 1 + QUO_BITS + 1;
    localparam int unsigned PROJ_LAT = 5;

    localparam logic signed [W_BITS-1:0] W_MAX    = 32'sh7FFF_FFFF;
    localparam logic [QUO_BITS-1:0]      UNIT_ONE = 31'h4000_0000;

    typedef logic signed [W_BITS-1:0] word_t;
    typedef word_t [2:0] row_t;

    // Divide by 2^sh, rounding half away from zero.
    function automatic logic signed [RND_BITS-1:0] rnd_shift(
        input logic signed [RND_BITS-1:0] x,
        input int unsigned sh
    );
        logic [RND_BITS-1:0] m;
        logic [RND_BITS-1:0] half;
        half = (RND_BITS'(1) << sh) >> 1;
        m = x[RND_BITS-1] ? (~x + RND_BITS'(1)) : x;
        m = (m + half) >> sh;
        rnd_shift = x[RND_BITS-1] ? -$signed(m) : $signed(m);
    endfunction

endpackage

// File: src/orthonormalize_3x3_rows_core.sv
// Top level of the 3x3 row orthonormalizer (modified Gram-Schmidt).
// Depends on ogs_pkg, ogs_norm, ogs_proj and ogs_delay.
//
//  channel | direction | tdata (low bit up)                | tuser
//  s_      | in        | a00 a01 a02 a10 a11 a12 a20 a21 a22 | -
//  m_      | out       | q00 q01 q02 q10 q11 q12 q20 q21 q22 | degenerate
//
// One item is accepted per cycle unless the output register stalls; each
// result passes through three normalize pipelines of 69 stages (32 square-root
// stages and 31 divider stages each), two projection pipelines of five
// stages and the output register.
// Reset clears only the valid bits. A stalled output register freezes the
// whole pipeline, and s_tready drops in the same cycle.
module orthonormalize_3x3_rows_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // a00, a01, a02, a10, a11, a12, a20, a21, a22
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // q00, q01, q02, q10, q11, q12, q20, q21, q22
    output logic [0:0]   m_tuser    // degenerate
);

    localparam int unsigned DB = ogs_pkg::DATA_BITS;
    localparam int unsigned RW = 3 * ogs_pkg::W_BITS;

    logic en;
    ogs_pkg::row_t w0_in, w1_in, w2_in;

    logic          v_a, z0_a;
    ogs_pkg::row_t u0_a, w1_a, w2_a;
    logic          v_b, z0_b;
    ogs_pkg::row_t w1_b, w2_b, u0_b;
    logic          v_c, z1_c, z0_c;
    ogs_pkg::row_t u1_c, w2_c, u0_c;
    logic          v_d, z0_d, z1_d;
    ogs_pkg::row_t w2_d, u1_d, u0_d;
    logic          v_e, z2_e, z0_e, z1_e;
    ogs_pkg::row_t u2_e, u0_e, u1_e;

    logic         degen;
    logic [143:0] q_next;
    logic signed [ogs_pkg::RND_BITS-1:0] rq;
    ogs_pkg::row_t urow [0:2];

    logic         out_valid_reg;
    logic [143:0] out_data_reg;
    logic         out_degen_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            w0_in[j] = ogs_pkg::W_BITS'($signed(s_tdata[DB*j +: DB])) <<< ogs_pkg::GUARD_BITS;
            w1_in[j] = ogs_pkg::W_BITS'($signed(s_tdata[DB*(3+j) +: DB]))
                       <<< ogs_pkg::GUARD_BITS;
            w2_in[j] = ogs_pkg::W_BITS'($signed(s_tdata[DB*(6+j) +: DB]))
                       <<< ogs_pkg::GUARD_BITS;
        end
    end

    // Row 0
    ogs_norm u_norm0 (
        .clk, .rst_n, .en,
        .in_valid (s_tvalid),
        .w_in     (w0_in),
        .out_valid(v_a),
        .u_out    (u0_a),
        .zero_out (z0_a)
    );

    ogs_delay #(.DEPTH(ogs_pkg::NORM_LAT), .WIDTH(2 * RW)) u_dly_a (
        .clk, .en,
        .din ({w1_in, w2_in}),
        .dout({w1_a, w2_a})
    );

    // Rows 1 and 2 lose their component along row 0 side by side.
    ogs_proj u_proj_b1 (
        .clk, .rst_n, .en,
        .in_valid (v_a),
        .w_in     (w1_a),
        .u_in     (u0_a),
        .out_valid(v_b),
        .w_out    (w1_b),
        .u_out    (u0_b)
    );

    ogs_proj u_proj_b2 (
        .clk, .rst_n, .en,
        .in_valid (v_a),
        .w_in     (w2_a),
        .u_in     (u0_a),
        .out_valid(),
        .w_out    (w2_b),
        .u_out    ()
    );

    ogs_delay #(.DEPTH(ogs_pkg::PROJ_LAT), .WIDTH(1)) u_dly_b (
        .clk, .en,
        .din (z0_a),
        .dout(z0_b)
    );

    // Row 1
    ogs_norm u_norm1 (
        .clk, .rst_n, .en,
        .in_valid (v_b),
        .w_in     (w1_b),
        .out_valid(v_c),
        .u_out    (u1_c),
        .zero_out (z1_c)
    );

    ogs_delay #(.DEPTH(ogs_pkg::NORM_LAT), .WIDTH(2 * RW + 1)) u_dly_c (
        .clk, .en,
        .din ({w2_b, u0_b, z0_b}),
        .dout({w2_c, u0_c, z0_c})
    );

    ogs_proj u_proj_c (
        .clk, .rst_n, .en,
        .in_valid (v_c),
        .w_in     (w2_c),
        .u_in     (u1_c),
        .out_valid(v_d),
        .w_out    (w2_d),
        .u_out    (u1_d)
    );

    ogs_delay #(.DEPTH(ogs_pkg::PROJ_LAT), .WIDTH(RW + 2)) u_dly_d (
        .clk, .en,
        .din ({u0_c, z0_c, z1_c}),
        .dout({u0_d, z0_d, z1_d})
    );

    // Row 2
    ogs_norm u_norm2 (
        .clk, .rst_n, .en,
        .in_valid (v_d),
        .w_in     (w2_d),
        .out_valid(v_e),
        .u_out    (u2_e),
        .zero_out (z2_e)
    );

    ogs_delay #(.DEPTH(ogs_pkg::NORM_LAT), .WIDTH(2 * RW + 2)) u_dly_e (
        .clk, .en,
        .din ({u0_d, u1_d, z0_d, z1_d}),
        .dout({u0_e, u1_e, z0_e, z1_e})
    );

    always_comb
    begin
        urow[0] = u0_e;
        urow[1] = u1_e;
        urow[2] = u2_e;
        degen   = z0_e || z1_e || z2_e;
        q_next  = '0;
        rq      = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                rq = ogs_pkg::rnd_shift(ogs_pkg::RND_BITS'($signed(urow[r][j])),
                                        ogs_pkg::OUT_SHIFT);
                if (degen)
                begin
                    q_next[DB*(3*r+j) +: DB] = '0;
                end
                else if (rq > ogs_pkg::RND_BITS'(32767))
                begin
                    q_next[DB*(3*r+j) +: DB] = 16'h7FFF;
                end
                else if (rq < -ogs_pkg::RND_BITS'(32768))
                begin
                    q_next[DB*(3*r+j) +: DB] = 16'h8000;
                end
                else
                begin
                    q_next[DB*(3*r+j) +: DB] = rq[DB-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v_e;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg  <= q_next;
            out_degen_reg <= degen;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_degen_reg;

endmodule

// File: src/ogs_delay.sv
// Register delay line with a shared stall enable.
// Keeps side data aligned with the row pipelines; uses no package items.
module ogs_delay #(
    parameter int unsigned DEPTH = 5,
    parameter int unsigned WIDTH = 8
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// File: src/ogs_proj.sv
// Removes the projection of a working row onto one unit row, five stages.
// Depends on ogs_pkg for formats and rounding.
module ogs_proj (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  ogs_pkg::row_t w_in,
    input  ogs_pkg::row_t u_in,
    output logic          out_valid,
    output ogs_pkg::row_t w_out,
    output ogs_pkg::row_t u_out
);

    logic [4:0] valid_reg;

    ogs_pkg::row_t w1_reg, w2_reg, w3_reg, w4_reg, w5_reg;
    ogs_pkg::row_t u1_reg, u2_reg, u3_reg, u4_reg, u5_reg;

    logic signed [63:0]                   prod1_reg [0:2];
    logic signed [65:0]                   acc2_reg;
    logic signed [ogs_pkg::S_BITS-1:0]    s3_reg;
    logic signed [65:0]                   prod4_reg [0:2];

    logic signed [63:0]                   prod1_next [0:2];
    logic signed [65:0]                   acc2_next;
    logic signed [ogs_pkg::RND_BITS-1:0]  s_full;
    logic signed [65:0]                   prod4_next [0:2];
    ogs_pkg::row_t                        w5_next;
    logic signed [ogs_pkg::RND_BITS-1:0]  corr;
    logic signed [ogs_pkg::RND_BITS-1:0]  diff;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            prod1_next[j] = $signed(w_in[j]) * $signed(u_in[j]);
        end
        acc2_next = 66'(prod1_reg[0]) + 66'(prod1_reg[1]) + 66'(prod1_reg[2]);
        s_full = ogs_pkg::rnd_shift(ogs_pkg::RND_BITS'(acc2_reg), ogs_pkg::UNIT_BITS);
        for (int j = 0; j < 3; j++)
        begin
            prod4_next[j] = s3_reg * $signed(u3_reg[j]);
        end
        corr = '0;
        diff = '0;
        for (int j = 0; j < 3; j++)
        begin
            corr = ogs_pkg::rnd_shift(ogs_pkg::RND_BITS'(prod4_reg[j]), ogs_pkg::UNIT_BITS);
            diff = ogs_pkg::RND_BITS'($signed(w4_reg[j])) - corr;
            if (diff > ogs_pkg::RND_BITS'(ogs_pkg::W_MAX))
            begin
                w5_next[j] = ogs_pkg::W_MAX;
            end
            else if (diff < -ogs_pkg::RND_BITS'(ogs_pkg::W_MAX))
            begin
                w5_next[j] = -ogs_pkg::W_MAX;
            end
            else
            begin
                w5_next[j] = diff[ogs_pkg::W_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg <= w_in;
            u1_reg <= u_in;
            for (int j = 0; j < 3; j++)
            begin
                prod1_reg[j] <= prod1_next[j];
                prod4_reg[j] <= prod4_next[j];
            end
            w2_reg   <= w1_reg;
            u2_reg   <= u1_reg;
            acc2_reg <= acc2_next;
            w3_reg   <= w2_reg;
            u3_reg   <= u2_reg;
            s3_reg   <= s_full[ogs_pkg::S_BITS-1:0];
            w4_reg   <= w3_reg;
            u4_reg   <= u3_reg;
            w5_reg   <= w5_next;
            u5_reg   <= u4_reg;
        end
    end

    assign out_valid = valid_reg[4];
    assign w_out     = w5_reg;
    assign u_out     = u5_reg;

endmodule

// File: src/ogs_norm.sv
// Normalizes one working row: squared norm, even shift, pipelined square
// root and three pipelined dividers. Depends on ogs_pkg.
module ogs_norm (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  ogs_pkg::row_t w_in,
    output logic          out_valid,
    output ogs_pkg::row_t u_out,
    output logic          zero_out
);

    localparam int unsigned RB = ogs_pkg::ROOT_BITS;
    localparam int unsigned QB = ogs_pkg::QUO_BITS;

    // Front stages
    logic [2:0]  fv_reg;
    logic [2:0]  neg1_reg, neg2_reg, neg3_reg;
    logic [31:0] m1_reg [0:2];
    logic [31:0] m2_reg [0:2];
    logic [31:0] m3_reg [0:2];
    logic [63:0] sq1_reg [0:2];
    logic [63:0] n2_reg, n3_reg;
    logic [4:0]  k3_reg;
    logic        zero3_reg;

    logic [31:0] m_next [0:2];
    logic [63:0] sq_next [0:2];
    logic [5:0]  msb;
    logic [4:0]  k_next;
    logic [63:0] x_wide [0:2];

    // Square root stages, entry 0 is the shift stage
    logic                   sv_reg    [0:RB];
    logic                   sz_reg    [0:RB];
    logic [2:0]             sn_reg    [0:RB];
    logic [ogs_pkg::X_BITS-1:0] sx_reg [0:RB][0:2];
    logic [63:0]            snn_reg   [0:RB];
    logic [34:0]            srem_reg  [0:RB];
    logic [RB-1:0]          sroot_reg [0:RB];

    // Divider stages, entry 0 is the setup stage
    logic                   dv_reg   [0:QB];
    logic                   dz_reg   [0:QB];
    logic [2:0]             dn_reg   [0:QB];
    logic [RB-1:0]          dr_reg   [0:QB];
    logic [ogs_pkg::NUM_BITS-1:0] dnum_reg [0:QB][0:2];
    logic [RB-1:0]          drem_reg [0:QB][0:2];
    logic [QB-1:0]          dq_reg   [0:QB][0:2];

    logic [ogs_pkg::NUM_BITS-1:0] num_next [0:2];

    logic          ov_reg;
    logic          oz_reg;
    ogs_pkg::row_t u_reg;
    ogs_pkg::row_t u_next;
    logic [QB-1:0] qc;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            m_next[j]  = w_in[j][ogs_pkg::W_BITS-1] ? 32'(-w_in[j]) : 32'(w_in[j]);
            sq_next[j] = 64'(m_next[j]) * 64'(m_next[j]);
        end
        msb = '0;
        for (int b = 0; b < 64; b++)
        begin
            if (n2_reg[b])
            begin
                msb = 6'(b);
            end
        end
        // Smallest even shift that lifts the norm to at least 2^60.
        k_next = (msb >= 6'd60) ? 5'd0 : 5'((7'd61 - 7'(msb)) >> 1);
        for (int j = 0; j < 3; j++)
        begin
            x_wide[j] = 64'(m3_reg[j]) << k3_reg;
        end
        for (int j = 0; j < 3; j++)
        begin
            num_next[j] = (ogs_pkg::NUM_BITS'(sx_reg[RB][j]) << ogs_pkg::UNIT_BITS)
                        + ogs_pkg::NUM_BITS'(sroot_reg[RB] >> 1);
        end
        qc = '0;
        for (int j = 0; j < 3; j++)
        begin
            qc = (dq_reg[QB][j] > ogs_pkg::UNIT_ONE) ? ogs_pkg::UNIT_ONE : dq_reg[QB][j];
            u_next[j] = dn_reg[QB][j] ? -ogs_pkg::W_BITS'(qc) : ogs_pkg::W_BITS'(qc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else if (en)
        begin
            fv_reg <= {fv_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                neg1_reg[j] <= w_in[j][ogs_pkg::W_BITS-1];
                m1_reg[j]   <= m_next[j];
                sq1_reg[j]  <= sq_next[j];
                m2_reg[j]   <= m1_reg[j];
                m3_reg[j]   <= m2_reg[j];
                sx_reg[0][j] <= x_wide[j][ogs_pkg::X_BITS-1:0];
            end
            neg2_reg  <= neg1_reg;
            n2_reg    <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
            neg3_reg  <= neg2_reg;
            n3_reg    <= n2_reg;
            k3_reg    <= k_next;
            zero3_reg <= (n2_reg == 64'd0);
            sz_reg[0]    <= zero3_reg;
            sn_reg[0]    <= neg3_reg;
            snn_reg[0]   <= n3_reg << {k3_reg, 1'b0};
            srem_reg[0]  <= '0;
            sroot_reg[0] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sv_reg[0] <= fv_reg[2];
        end
    end

    // One root bit per stage.
    for (genvar s = 0; s < RB; s++)
    begin : g_sqrt
        localparam int unsigned I = RB - 1 - s;
        logic [34:0] rem_sh;
        logic [34:0] trial;
        logic        ge;

        always_comb
        begin
            rem_sh = {srem_reg[s][32:0], snn_reg[s][2*I+1 -: 2]};
            trial  = {1'b0, sroot_reg[s], 2'b01};
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                sv_reg[s+1] <= sv_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sz_reg[s+1]    <= sz_reg[s];
                sn_reg[s+1]    <= sn_reg[s];
                snn_reg[s+1]   <= snn_reg[s];
                srem_reg[s+1]  <= ge ? (rem_sh - trial) : rem_sh;
                sroot_reg[s+1] <= {sroot_reg[s][RB-2:0], ge};
                for (int j = 0; j < 3; j++)
                begin
                    sx_reg[s+1][j] <= sx_reg[s][j];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_reg[0] <= sv_reg[RB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dz_reg[0] <= sz_reg[RB];
            dn_reg[0] <= sn_reg[RB];
            dr_reg[0] <= sroot_reg[RB];
            for (int j = 0; j < 3; j++)
            begin
                dnum_reg[0][j] <= num_next[j];
                drem_reg[0][j] <= num_next[j][ogs_pkg::NUM_BITS-1 -: RB];
                dq_reg[0][j]   <= '0;
            end
        end
    end

    // One quotient bit per stage for each of the three elements.
    for (genvar s = 0; s < QB; s++)
    begin : g_div
        localparam int unsigned I = QB - 1 - s;
        logic [RB:0] rem_sh [0:2];
        logic        ge     [0:2];

        always_comb
        begin
            for (int j = 0; j < 3; j++)
            begin
                rem_sh[j] = {drem_reg[s][j], dnum_reg[s][j][I]};
                ge[j]     = (rem_sh[j] >= {1'b0, dr_reg[s]});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[s+1] <= dv_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dz_reg[s+1] <= dz_reg[s];
                dn_reg[s+1] <= dn_reg[s];
                dr_reg[s+1] <= dr_reg[s];
                for (int j = 0; j < 3; j++)
                begin
                    dnum_reg[s+1][j] <= dnum_reg[s][j];
                    drem_reg[s+1][j] <= ge[j] ? RB'(rem_sh[j] - {1'b0, dr_reg[s]})
                                              : RB'(rem_sh[j]);
                    dq_reg[s+1][j]   <= {dq_reg[s][j][QB-2:0], ge[j]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= dv_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oz_reg <= dz_reg[QB];
            u_reg  <= u_next;
        end
    end

    assign out_valid = ov_reg;
    assign u_out     = u_reg;
    assign zero_out  = oz_reg;

endmodule

// File: src/ogs_checker.sv
// Port-level checks for the 3x3 row orthonormalizer, bound to its top level.
// Depends only on the top level's ports.
module ogs_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [143:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata,
    input logic [0:0]   m_tuser
);

    // A result held back by the consumer keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // With the output register empty the pipeline never stalls.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // A degenerate matrix gives an all-zero result.
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 144'd0)
        else $error("degenerate result not zero");

    // Every element of a unit row lies within plus or minus one.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            ($signed(m_tdata[15:0])    >= -16384 && $signed(m_tdata[15:0])    <= 16384) &&
            ($signed(m_tdata[31:16])   >= -16384 && $signed(m_tdata[31:16])   <= 16384) &&
            ($signed(m_tdata[47:32])   >= -16384 && $signed(m_tdata[47:32])   <= 16384) &&
            ($signed(m_tdata[63:48])   >= -16384 && $signed(m_tdata[63:48])   <= 16384) &&
            ($signed(m_tdata[79:64])   >= -16384 && $signed(m_tdata[79:64])   <= 16384) &&
            ($signed(m_tdata[95:80])   >= -16384 && $signed(m_tdata[95:80])   <= 16384) &&
            ($signed(m_tdata[111:96])  >= -16384 && $signed(m_tdata[111:96])  <= 16384) &&
            ($signed(m_tdata[127:112]) >= -16384 && $signed(m_tdata[127:112]) <= 16384) &&
            ($signed(m_tdata[143:128]) >= -16384 && $signed(m_tdata[143:128]) <= 16384))
        else $error("result element out of range");

endmodule

bind orthonormalize_3x3_rows_core ogs_checker u_ogs_checker (.*);

// File: test/orthonormalize_3x3_rows_core_test.sv
// Self-checking testbench for orthonormalize_3x3_rows_core, the 3x3 row orthonormalizer.
// Depends on ogs_pkg and the block's RTL; it predicts each matrix with its own fixed-point model.
`timescale 1ns / 1ps

module orthonormalize_3x3_rows_core_test;

    typedef struct packed {
        logic [143:0] q;
        logic         degenerate;
    } ortho_t;

    int unsigned mismatch_count = 0;

    task automatic report(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Divide by 2^sh, rounding half away from zero.
    function automatic longint round_shift(input longint x, input int sh);
        longint unsigned m;
        if (sh == 0)
            return x;
        m = (x < 0) ? -x : x;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return (x < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic ortho_t orthonormalize(input logic [143:0] mat);
        longint u [3][3];
        longint w [3];
        longint acc, s;
        longint unsigned n, nn, r, m;
        logic [127:0] num;
        logic [127:0] quo;
        int sh;
        ortho_t res;
        res = '0;
        for (int i = 0; i < 3 && !res.degenerate; i++)
        begin
            for (int j = 0; j < 3; j++)
                w[j] = longint'($signed(mat[(i*3+j)*16 +: 16])) <<< ogs_pkg::GUARD_BITS;
            for (int k = 0; k < i; k++)
            begin
                acc = 0;
                for (int j = 0; j < 3; j++)
                    acc += w[j] * u[k][j];
                s = round_shift(acc, ogs_pkg::UNIT_BITS);
                for (int j = 0; j < 3; j++)
                    w[j] = clamp(w[j] - round_shift(s * u[k][j], ogs_pkg::UNIT_BITS),
                                 -64'sd2147483647, 64'sd2147483647);
            end
            n = 0;
            for (int j = 0; j < 3; j++)
            begin
                m = (w[j] < 0) ? -w[j] : w[j];
                n += m * m;
            end
            if (n == 0)
                res.degenerate = 1'b1;
            else
            begin
                nn = n;
                sh = 0;
                while (nn < (64'd1 << 60))
                begin
                    nn <<= 2;
                    sh++;
                end
                r = int_sqrt(nn);
                for (int j = 0; j < 3; j++)
                begin
                    m = (w[j] < 0) ? -w[j] : w[j];
                    // This is done in 64 bits; the product stays below 2^64.
                    num = 128'(64'((m << sh) << ogs_pkg::UNIT_BITS)) + 128'(r / 2);
                    quo = num / r;
                    if (quo > (128'd1 << ogs_pkg::UNIT_BITS))
                        quo = 128'd1 << ogs_pkg::UNIT_BITS;
                    u[i][j] = (w[j] < 0) ? -longint'(quo) : longint'(quo);
                end
            end
        end
        if (!res.degenerate)
            for (int i = 0; i < 9; i++)
                res.q[i*16 +: 16] = 16'(clamp(round_shift(u[i/3][i%3], ogs_pkg::OUT_SHIFT),
                                              -32768, 32767));
        return res;
    endfunction

    class ortho_scoreboard;
        ortho_t pending[$];

        function void note_matrix(input logic [143:0] mat);
            pending.push_back(orthonormalize(mat));
        endfunction

        task check_result(input logic [143:0] q, input logic degen);
            ortho_t exp_res;
            if (pending.size() == 0)
            begin
                report("result with no matrix outstanding");
                return;
            end
            exp_res = pending.pop_front();
            for (int i = 0; i < 9; i++)
                if (q[i*16 +: 16] !== exp_res.q[i*16 +: 16])
                    report($sformatf("q%0d%0d got %0d expected %0d", i / 3, i % 3,
                           $signed(q[i*16 +: 16]), $signed(exp_res.q[i*16 +: 16])));
            if (degen !== exp_res.degenerate)
                report($sformatf("degenerate got %b expected %b", degen,
                       exp_res.degenerate));
        endtask
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;
    logic [0:0]   m_tuser;

    ortho_scoreboard board = new();
    logic [143:0] stimulus[$];
    bit           sending_done = 1'b0;
    bit           long_hold = 1'b0;

    orthonormalize_3x3_rows_core DUT (.*);

    always #5 clk = ~clk;

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [15:0] random_element();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [143:0] random_matrix();
        logic [143:0] mat;
        logic signed [15:0] c;
        for (int i = 0; i < 9; i++)
            mat[i*16 +: 16] = random_element();
        case ($urandom_range(0, 9))
            // Row 2 a copy of row 0, row 1 about half of row 0, or one row all zero.
            0: for (int j = 0; j < 3; j++)
                    mat[(6+j)*16 +: 16] = mat[j*16 +: 16];
            1: for (int j = 0; j < 3; j++)
                begin
                    c = $signed(mat[j*16 +: 16]) >>> 1;
                    mat[(3+j)*16 +: 16] = c + 16'(int'($urandom_range(0, 2)) - 1);
                end
            2: mat[$urandom_range(0, 2)*48 +: 48] = '0;
            default: ;
        endcase
        return mat;
    endfunction

    function automatic logic [143:0] make_matrix(input int e[9]);
        logic [143:0] mat;
        for (int i = 0; i < 9; i++)
            mat[i*16 +: 16] = 16'(e[i]);
        return mat;
    endfunction

    task automatic send_matrices();
        logic [143:0] mat;
        int gap;
        while (stimulus.size() > 0)
        begin
            mat = stimulus.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= mat;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            board.note_matrix(mat);
            gap = (long_hold || $urandom_range(0, 3) == 0) ? 0 : gap_length();
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;
        sending_done = 1'b1;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        stimulus.push_back(make_matrix('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}));
        stimulus.push_back(make_matrix('{-32768, -32768, -32768, 32767, 32767, 32767,
                                         -32768, 0, 32767}));
        stimulus.push_back(make_matrix('{32767, 32767, 32767, -32768, 32767, -32768,
                                         32767, -32768, -32768}));
        stimulus.push_back(make_matrix('{0, 0, 0, 1, 2, 3, 4, 5, 6}));
        stimulus.push_back(make_matrix('{1, 2, 3, 2, 4, 6, 7, 8, 9}));
        stimulus.push_back(make_matrix('{1, 2, 3, 4, 5, 6, 0, 0, 0}));
        stimulus.push_back(make_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1}));
        stimulus.push_back(make_matrix('{-1, 0, 0, 0, -1, 0, 0, 0, -1}));
        stimulus.push_back(make_matrix('{1000, 2000, 3000, 1000, 2000, 3001,
                                         1, 1, 0}));
        stimulus.push_back(make_matrix('{-32768, 0, 0, 0, 0, -32768, 1, 1, 1}));
        stimulus.push_back(make_matrix('{4096, 4096, 0, 4096, 4096, 1, 4096, 4095, 1}));
        stimulus.push_back(make_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
        for (int i = 0; i < 1640; i++)
            stimulus.push_back(random_matrix());
        send_matrices();
    end

    // Receiver: random stalls, and one long hold-off while the sender keeps offering.
    initial
    begin
        int count;
        int gap;
        count = 0;
        @(posedge rst_n);
        while (!sending_done || board.pending.size() > 0)
        begin
            if (count == 400)
            begin
                long_hold = 1'b1;
                m_tready <= 1'b0;
                repeat (600) @(posedge clk);
                long_hold = 1'b0;
            end
            gap = ($urandom_range(0, 2) == 0) ? gap_length() : 0;
            if (count > 1200 && count < 1400)
                gap = 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            if (m_tvalid)
            begin
                board.check_result(m_tdata, m_tuser[0]);
                count++;
            end
        end
        m_tready <= 1'b1;
        repeat (300)
        begin
            @(posedge clk);
            if (m_tvalid)
                board.check_result(m_tdata, m_tuser[0]);
        end
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
